[design/bbc_pkg.sv]
// Shared types and constants for the bracket balance checker.
// No dependencies; used by every other file of the block.
package bbc_pkg;

   // Bracket kind held in each stack cell
   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // Verdict codes, also the sticky error codes
   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_KIND     = 3'd1,
      ERR_EMPTY    = 3'd2,
      ERR_UNCLOSED = 3'd3,
      ERR_OVERFLOW = 3'd4
   } err_type;

   // Character codes that matter
   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28; // (
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29; // )
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B; // [
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D; // ]
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B; // {
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D; // }

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   // Shift command broadcast from the control unit to the row of cells
   typedef struct packed {
      logic     push;
      logic     pop;
      kind_type kind;
   } stack_cmd_type;

endpackage

[design/bbc_cell.sv]
// One stack cell: holds a bracket kind and shifts with its neighbors.
// Depends on bbc_pkg.
module bbc_cell (
   input  logic                  clock,
   input  bbc_pkg::stack_cmd_type cmd,
   input  bbc_pkg::kind_type     left_kind,   // from the cell nearer the top
   input  bbc_pkg::kind_type     right_kind,  // from the cell deeper down
   output bbc_pkg::kind_type     kind_out
);

   bbc_pkg::kind_type kind_ff;
   bbc_pkg::kind_type kind_in;

   always_comb begin
      kind_in = kind_ff;
      if (cmd.push) begin
         kind_in = left_kind;   // shift down on push
      end else if (cmd.pop) begin
         kind_in = right_kind;  // shift up on pop
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind_out = kind_ff;

endmodule

[design/bbc_ctrl.sv]
// Control unit: decodes characters, tracks depth and sticky error, forms verdict.
// Depends on bbc_pkg.
module bbc_ctrl #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             char_code,
   input  logic                   end_of_string,
   input  bbc_pkg::kind_type      top_kind,
   output bbc_pkg::stack_cmd_type cmd,
   output bbc_pkg::err_type       verdict
);

   localparam int DepthWidth = $clog2(STACK_DEPTH + 1);

   logic [DepthWidth-1:0] depth_ff, depth_in, depth_next;
   bbc_pkg::err_type      error_ff, error_in, error_next;
   bbc_pkg::kind_type     open_kind, close_kind;
   logic                  is_open, is_close, active, full, empty;

   always_comb begin
      open_kind  = bbc_pkg::KIND_NONE;
      close_kind = bbc_pkg::KIND_NONE;
      case (char_code)
         bbc_pkg::CHAR_OPEN_ROUND:   open_kind  = bbc_pkg::KIND_ROUND;
         bbc_pkg::CHAR_OPEN_SQUARE:  open_kind  = bbc_pkg::KIND_SQUARE;
         bbc_pkg::CHAR_OPEN_CURLY:   open_kind  = bbc_pkg::KIND_CURLY;
         bbc_pkg::CHAR_CLOSE_ROUND:  close_kind = bbc_pkg::KIND_ROUND;
         bbc_pkg::CHAR_CLOSE_SQUARE: close_kind = bbc_pkg::KIND_SQUARE;
         bbc_pkg::CHAR_CLOSE_CURLY:  close_kind = bbc_pkg::KIND_CURLY;
         default: ;
      endcase
   end

   assign is_open  = (open_kind != bbc_pkg::KIND_NONE);
   assign is_close = (close_kind != bbc_pkg::KIND_NONE);
   assign active   = accept && (error_ff == bbc_pkg::ERR_NONE);
   assign full     = (depth_ff == DepthWidth'(STACK_DEPTH));
   assign empty    = (depth_ff == '0);

   assign cmd.push = active && is_open && !full;
   assign cmd.pop  = active && is_close && !empty;
   assign cmd.kind = open_kind;

   always_comb begin
      error_next = error_ff;
      if (active) begin
         if (is_open && full) begin
            error_next = bbc_pkg::ERR_OVERFLOW;
         end else if (is_close && empty) begin
            error_next = bbc_pkg::ERR_EMPTY;
         end else if (is_close && (top_kind != close_kind)) begin
            error_next = bbc_pkg::ERR_KIND;
         end
      end
   end

   always_comb begin
      depth_next = depth_ff;
      if (cmd.push) begin
         depth_next = depth_ff + DepthWidth'(1);
      end else if (cmd.pop) begin
         depth_next = depth_ff - DepthWidth'(1);
      end
   end

   always_comb begin
      if (error_next != bbc_pkg::ERR_NONE) begin
         verdict = error_next;
      end else if (depth_next != '0) begin
         verdict = bbc_pkg::ERR_UNCLOSED;
      end else begin
         verdict = bbc_pkg::ERR_NONE;
      end
   end

   // Clear for the next string after the final character
   always_comb begin
      depth_in = depth_next;
      error_in = error_next;
      if (accept && end_of_string) begin
         depth_in = '0;
         error_in = bbc_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         error_ff <= bbc_pkg::ERR_NONE;
      end else begin
         depth_ff <= depth_in;
         error_ff <= error_in;
      end
   end

endmodule

[design/bracket_balance_checker_core.sv]
// Top level of the bracket balance checker: control unit, row of stack cells,
// output register. Depends on bbc_pkg, bbc_cell and bbc_ctrl.
//
// Usage:
//   A string arrives one character per beat on the req_ channel: req_tdata
//   carries the character byte and req_tlast marks its final character.
//   Opening brackets ( [ { push their kind, closing brackets pop and compare,
//   other bytes are ignored. The first error of a string sticks.
//   On the final character one beat leaves on the rsp_ channel with
//   matched in bit 0 and the reason code in bits 3:1 (0 ok, 1 wrong kind,
//   2 close on empty, 3 unclosed opens, 4 overflow).
//   Throughput: one character per cycle while no verdict is stalled on rsp_.
//   The stack is a row of STACK_DEPTH cells that all shift by one position in
//   the same cycle, so a push or pop is done together with its compare
//   against the top cell. The verdict is registered and appears on rsp_ the
//   cycle after the final character is accepted.
//   Stall: the output register holds the verdict while rsp_tready is low;
//   req_tready is high only while that register is empty or being drained,
//   so any character, final or not, waits while a verdict sits stalled.
//   Reset: synchronous, active high; clears depth, sticky error and the
//   output valid. The stack cells are not cleared (only pushed entries are
//   ever read), so no clearing pass is needed.
module bracket_balance_checker_core #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bbc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // [7:0] char_code
   input  logic                                req_tlast,  // end_of_string
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bbc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata   // [0] matched, [3:1] fail_reason
);

   logic                   req_accept;
   bbc_pkg::stack_cmd_type cmd;
   bbc_pkg::err_type       verdict;
   bbc_pkg::kind_type      cell_kind [STACK_DEPTH];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [bbc_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // Take a beat whenever the output slot is free or being freed this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   bbc_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .char_code     (req_tdata[7:0]),
      .end_of_string (req_tlast),
      .top_kind      (cell_kind[0]),
      .cmd           (cmd),
      .verdict       (verdict)
   );

   // Stack as a shift row: cell 0 is the top, pushes shift toward the end
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      bbc_pkg::kind_type left_kind, right_kind;
      if (i == 0) begin : g_top
         assign left_kind = cmd.kind;
      end else begin : g_mid_left
         assign left_kind = cell_kind[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign right_kind = cell_kind[i];
      end else begin : g_mid_right
         assign right_kind = cell_kind[i+1];
      end
      bbc_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_kind  (left_kind),
         .right_kind (right_kind),
         .kind_out   (cell_kind[i])
      );
   end

   // Output register: load on a final character, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, verdict, (verdict == bbc_pkg::ERR_NONE)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[design/bbc_checker.sv]
// Port-level checker for bracket_balance_checker_core, with its bind.
// Depends on bbc_pkg.
module bbc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bbc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // A stalled verdict beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed under stall");

   // matched agrees with the reason code
   a_matched_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == bbc_pkg::ERR_NONE)))
      else $error("matched flag disagrees with reason");

   // Reason in range and padding zero
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:1] <= bbc_pkg::ERR_OVERFLOW) && (rsp_tdata[7:4] == 4'b0000))
      else $error("reason code out of range");

   // A final character into an empty output slot yields a verdict next cycle
   a_verdict_out: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && !rsp_tvalid |=> rsp_tvalid)
      else $error("missing verdict after final character");

   // Nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/bbc_tb_pkg.sv]
`timescale 1ns / 100ps
// Verdict scoreboard for the bracket balance checker bench: bracket stack
// predictor plus the queue of verdicts still owed. Depends on bbc_pkg.
package bbc_tb_pkg;
   import bbc_pkg::*;

   typedef struct packed {
      logic    matched;
      err_type reason;
   } verdict_type;

   class verdict_scoreboard;
      int unsigned  depth_limit;
      kind_type     open_kinds[];
      int unsigned  fill;
      err_type      first_err;
      verdict_type  owed_verdicts[$];
      int unsigned  mismatches;

      function new(input int unsigned depth);
         depth_limit = depth;
         open_kinds  = new[depth];
         fill        = 0;
         first_err   = ERR_NONE;
         mismatches  = 0;
      endfunction

      // Advance the predicted stack by one accepted character beat.
      function void note_char(input logic [7:0] c, input logic last);
         kind_type    k;
         bit          is_open;
         bit          is_close;
         verdict_type v;
         is_open  = 1'b0;
         is_close = 1'b0;
         k        = KIND_NONE;
         case (c)
            CHAR_OPEN_ROUND:   begin is_open = 1'b1;  k = KIND_ROUND;  end
            CHAR_OPEN_SQUARE:  begin is_open = 1'b1;  k = KIND_SQUARE; end
            CHAR_OPEN_CURLY:   begin is_open = 1'b1;  k = KIND_CURLY;  end
            CHAR_CLOSE_ROUND:  begin is_close = 1'b1; k = KIND_ROUND;  end
            CHAR_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
            CHAR_CLOSE_CURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
            default: ;
         endcase
         if (first_err == ERR_NONE) begin
            if (is_open) begin
               if (fill >= depth_limit) begin
                  first_err = ERR_OVERFLOW;
               end else begin
                  open_kinds[fill] = k;
                  fill++;
               end
            end else if (is_close) begin
               if (fill == 0) begin
                  first_err = ERR_EMPTY;
               end else begin
                  fill--;
                  if (open_kinds[fill] != k) first_err = ERR_KIND;
               end
            end
         end
         if (last) begin
            if (first_err != ERR_NONE) v.reason = first_err;
            else if (fill != 0)        v.reason = ERR_UNCLOSED;
            else                       v.reason = ERR_NONE;
            v.matched = (v.reason == ERR_NONE);
            owed_verdicts.push_back(v);
            fill      = 0;
            first_err = ERR_NONE;
         end
      endfunction

      task report(input string msg);
         mismatches++;
         if (mismatches <= 50) $display("ERROR @%0t: %s", $time, msg);
      endtask

      // Compare one verdict beat against the oldest owed verdict.
      task check_verdict(input logic [7:0] tdata);
         verdict_type want;
         if (owed_verdicts.size() == 0) begin
            report($sformatf("verdict 0x%02h with none owed", tdata));
            return;
         end
         want = owed_verdicts.pop_front();
         if (tdata[0] !== want.matched)
            report($sformatf("matched %b, want %b", tdata[0], want.matched));
         if (tdata[3:1] !== want.reason)
            report($sformatf("reason %0d, want %0d", tdata[3:1], want.reason));
      endtask

      function int unsigned owed();
         return owed_verdicts.size();
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Bench top for bracket_balance_checker_core: drives strings on req_, checks
// verdicts on rsp_. Depends on bbc_pkg, bbc_tb_pkg and the block's RTL.
module tb_top;
   import bbc_pkg::*;
   import bbc_tb_pkg::*;

   localparam int DEPTH = 128;

   typedef enum {FLAW_NONE, FLAW_UNCLOSED, FLAW_WRONG_KIND, FLAW_STRAY_CLOSE} flaw_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] char_code
   logic       req_tlast;   // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [0] matched, [3:1] fail_reason

   verdict_scoreboard verdict_board;
   logic [7:0]  text[$];          // characters of the string being built
   bit          calm;             // no random idling on either side while set
   int unsigned rsp_hold_cycles;  // long receiver hold-off, taken once
   int unsigned items_sent;

   bracket_balance_checker_core #(.STACK_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] open_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_OPEN_ROUND;
         KIND_SQUARE: return CHAR_OPEN_SQUARE;
         default:     return CHAR_OPEN_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] close_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_CLOSE_ROUND;
         KIND_SQUARE: return CHAR_CLOSE_SQUARE;
         default:     return CHAR_CLOSE_CURLY;
      endcase
   endfunction

   function automatic int unsigned draw_gap();
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // Offer one character beat; entered and left at a falling edge.
   task automatic send_char(input logic [7:0] c, input logic last);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      verdict_board.note_char(c, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic send_word(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Drop valid and hold until every owed verdict has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (verdict_board.owed() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Random nested string plus random noise bytes, optionally broken on purpose.
   task automatic build_nested(input flaw_type flaw);
      kind_type    open_stack[$];
      kind_type    k;
      int unsigned len;
      int unsigned pick;
      int          closes[$];
      int          at;
      logic [7:0]  b;
      text.delete();
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            b = 8'($urandom_range(0, 255));
            text.push_back(b);
         end else if (pick < 6 || open_stack.size() == 0) begin
            k = kind_type'($urandom_range(0, 2));
            open_stack.push_back(k);
            text.push_back(open_char(k));
         end else begin
            text.push_back(close_char(open_stack.pop_back()));
         end
      end
      if (flaw == FLAW_UNCLOSED) begin
         if (open_stack.size() == 0) text.push_back(open_char(kind_type'($urandom_range(0, 2))));
      end else begin
         while (open_stack.size() != 0) text.push_back(close_char(open_stack.pop_back()));
      end
      if (flaw == FLAW_WRONG_KIND) begin
         for (int i = 0; i < text.size(); i++)
            if (text[i] == CHAR_CLOSE_ROUND || text[i] == CHAR_CLOSE_SQUARE ||
                text[i] == CHAR_CLOSE_CURLY) closes.push_back(i);
         if (closes.size() != 0) begin
            at = closes[$urandom_range(0, closes.size() - 1)];
            b  = text[at];
            do b = close_char(kind_type'($urandom_range(0, 2))); while (b == text[at]);
            text[at] = b;
         end
      end
      if (flaw == FLAW_STRAY_CLOSE)
         text.insert($urandom_range(0, text.size()), close_char(kind_type'($urandom_range(0, 2))));
   endtask

   task automatic build_deep(input int unsigned opens, input bit close_all);
      kind_type open_stack[$];
      kind_type k;
      text.delete();
      repeat (opens) begin
         k = kind_type'($urandom_range(0, 2));
         open_stack.push_back(k);
         text.push_back(open_char(k));
      end
      if (close_all)
         while (open_stack.size() != 0) text.push_back(close_char(open_stack.pop_back()));
   endtask

   // Receiver: random hold-off per verdict, one long hold on request.
   initial begin : rsp_side
      int unsigned gap;
      forever begin
         @(negedge clock);
         gap = draw_gap();
         if (rsp_hold_cycles != 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         verdict_board.check_verdict(rsp_tdata);
      end
   end

   initial begin : run_limit
      #5_000_000;
      $display("FAIL bracket_balance_checker_core");
      $finish;
   end

   initial begin : req_side
      int unsigned str_idx;
      int unsigned pick;
      logic [7:0]  b;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = 8'h00;
      req_tlast       = 1'b0;
      rsp_tready      = 1'b0;
      calm            = 1'b0;
      rsp_hold_cycles = 0;
      items_sent      = 0;
      verdict_board   = new(DEPTH);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: plain pairs, wrong-kind, close-on-empty and unclosed errors, errors
      // followed by more input, a nested run and the byte extremes.
      send_word("a");
      send_word("()");
      send_word("[]");
      send_word("{}");
      send_word("(]");
      send_word("[}");
      send_word("{)");
      send_word(")({");
      send_word("((");
      send_word("([{}])");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h80, 1'b1);
      drain();
      items_sent = 0;

      str_idx = 0;
      while (items_sent < 850) begin
         str_idx++;
         if (str_idx % 5 == 0) calm = ($urandom_range(0, 3) == 0);
         if (str_idx == 5) begin
            // Stall the receiver while the sender keeps streaming, so the
            // verdict slot fills and req_tready drops; then wait everything out.
            calm            = 1'b1;
            rsp_hold_cycles = 400;
            repeat (16) begin
               build_nested(FLAW_NONE);
               send_text();
            end
            calm = 1'b0;
            drain();
         end else if (str_idx == 8) begin
            build_deep(DEPTH, 1'b1);        // exactly full stack, then unwound
            send_text();
         end else if (str_idx == 10) begin
            build_deep(DEPTH + 1, 1'b0);    // overflow on the final character
            send_text();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               build_nested(FLAW_NONE);
            end else if (pick < 72) begin
               build_nested(FLAW_UNCLOSED);
            end else if (pick < 80) begin
               build_nested(FLAW_WRONG_KIND);
            end else if (pick < 88) begin
               build_nested(FLAW_STRAY_CLOSE);
            end else if (pick < 95) begin
               text.delete();
               repeat ($urandom_range(1, 6)) begin
                  b = 8'($urandom_range(0, 255));
                  text.push_back(b);
               end
            end else begin
               build_deep($urandom_range(20, 60), $urandom_range(0, 1));
            end
            send_text();
         end
      end

      req_tvalid <= 1'b0;
      while (verdict_board.owed() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (verdict_board.mismatches == 0)
         $display("PASS bracket_balance_checker_core");
      else
         $display("FAIL bracket_balance_checker_core");
      $finish;
   end

endmodule
